@@ design/three_stage_multiserver_queue_timing_top_macros.svh @@
// ---------------------------------------------------------------------------
// three_stage_multiserver_queue_timing_top_macros
// assertion helpers shared by the queue timing design files
// ---------------------------------------------------------------------------
`ifndef THREE_STAGE_MULTISERVER_QUEUE_TIMING_TOP_MACROS_SVH
`define THREE_STAGE_MULTISERVER_QUEUE_TIMING_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define TSQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// condition must never be seen outside reset
`define TSQ_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define TSQ_ASSERT(name, prop, msg)
`define TSQ_NEVER(name, cond, msg)
`endif

`endif

@@ design/tsq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsq_pkg
// shared widths, register indexes and stage settings for the queue timing block
// ---------------------------------------------------------------------------
package tsq_pkg;

  // fixed field widths of the stream items and registers
  localparam int unsigned FIELD_W   = 48;
  localparam int unsigned SRV_W     = 5;
  localparam int unsigned SVC_W     = 30;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRV_ONE   = 3'd0,
    CFG_SRV_TWO   = 3'd1,
    CFG_SRV_THREE = 3'd2,
    CFG_SVC_ONE   = 3'd3,
    CFG_SVC_TWO   = 3'd4,
    CFG_SVC_THREE = 3'd5
  } cfg_idx_e;

  // settings of one service stage
  typedef struct packed {
    logic [SRV_W-1:0] servers;
    logic [SVC_W-1:0] service;
  } stage_cfg_t;

endpackage

@@ design/tsq_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsq_cfg
// register file holding server counts and service times of the three stages
// ---------------------------------------------------------------------------
module tsq_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsq_pkg::SVC_W-1:0]      cfg_data_i,
  output tsq_pkg::stage_cfg_t            cfg_one_o,
  output tsq_pkg::stage_cfg_t            cfg_two_o,
  output tsq_pkg::stage_cfg_t            cfg_three_o
);

  tsq_pkg::stage_cfg_t one_q, two_q, three_q;

  // register writes, all fields reset to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q   <= '{servers: tsq_pkg::SRV_W'(1), service: tsq_pkg::SVC_W'(1)};
      two_q   <= '{servers: tsq_pkg::SRV_W'(1), service: tsq_pkg::SVC_W'(1)};
      three_q <= '{servers: tsq_pkg::SRV_W'(1), service: tsq_pkg::SVC_W'(1)};
    end else if (cfg_we_i) begin
      case (tsq_pkg::cfg_idx_e'(cfg_idx_i))
        tsq_pkg::CFG_SRV_ONE:   one_q.servers   <= cfg_data_i[tsq_pkg::SRV_W-1:0];
        tsq_pkg::CFG_SRV_TWO:   two_q.servers   <= cfg_data_i[tsq_pkg::SRV_W-1:0];
        tsq_pkg::CFG_SRV_THREE: three_q.servers <= cfg_data_i[tsq_pkg::SRV_W-1:0];
        tsq_pkg::CFG_SVC_ONE:   one_q.service   <= cfg_data_i;
        tsq_pkg::CFG_SVC_TWO:   two_q.service   <= cfg_data_i;
        tsq_pkg::CFG_SVC_THREE: three_q.service <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_one_o   = one_q;
  assign cfg_two_o   = two_q;
  assign cfg_three_o = three_q;

endmodule

@@ design/tsq_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsq_front
// accepts arrivals, saturates them to the time range and queues them
// ---------------------------------------------------------------------------
`include "three_stage_multiserver_queue_timing_top_macros.svh"

module tsq_front #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [tsq_pkg::FIELD_W-1:0]   s_arrival_i,
  input  logic                          s_last_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output logic [TIME_BITS-1:0]          q_arrival_o,
  output logic                          q_last_o
);

  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  logic [TIME_BITS-1:0] arr_sat;
  logic [63:0]          arr_wide;
  logic                 push, pop;

  logic [TIME_BITS-1:0] arr_mem_q [2];
  logic                 last_mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;

  // clamp arrivals above the time range
  always_comb begin
    arr_wide = 64'(s_arrival_i);
    arr_sat  = (arr_wide > 64'(TimeMax)) ? TimeMax : arr_wide[TIME_BITS-1:0];
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // two-entry item queue between intake and the service stages
  always_ff @(posedge clk_i) begin
    if (push) begin
      arr_mem_q[wr_ptr_q]  <= arr_sat;
      last_mem_q[wr_ptr_q] <= s_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign q_arrival_o = arr_mem_q[rd_ptr_q];
  assign q_last_o    = last_mem_q[rd_ptr_q];

  `TSQ_NEVER(a_queue_overflow, cnt_q == 2'd3, "item queue count out of range")

endmodule

@@ design/tsq_stage.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsq_stage
// one multi-server service stage with a ring of server completion times
// ---------------------------------------------------------------------------
`include "three_stage_multiserver_queue_timing_top_macros.svh"

module tsq_stage #(
  parameter int unsigned MAX_SERVERS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsq_pkg::stage_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_BITS-1:0] in_arrival_i,
  input  logic [TIME_BITS-1:0] in_time_i,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TIME_BITS-1:0] out_arrival_o,
  output logic [TIME_BITS-1:0] out_time_o,
  output logic                 out_last_o
);

  localparam int unsigned SLOT_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SERVERS + 1);
  localparam int unsigned CW     = (CNT_W > tsq_pkg::SRV_W) ? CNT_W : tsq_pkg::SRV_W;

  logic [TIME_BITS-1:0] ring_q [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_q;
  logic [SLOT_W-1:0]    slot_q;

  logic                 out_valid_q, out_last_q;
  logic [TIME_BITS-1:0] out_arrival_q, out_time_q;

  logic [CW-1:0]        srv_ext, n_eff, slot_ext, p_ext, p_inc;
  logic [SLOT_W-1:0]    p, slot_d;
  logic [TIME_BITS-1:0] busy_until, start, done;
  logic [TIME_BITS:0]   sum;
  logic                 in_fire;

  // effective server count and the slot used by this item
  always_comb begin
    srv_ext  = CW'(cfg_i.servers);
    if (srv_ext == '0) begin
      n_eff = CW'(1);
    end else if (srv_ext > CW'(MAX_SERVERS)) begin
      n_eff = CW'(MAX_SERVERS);
    end else begin
      n_eff = srv_ext;
    end
    slot_ext = CW'(slot_q);
    p_ext    = (slot_ext >= n_eff) ? '0 : slot_ext;
    p        = p_ext[SLOT_W-1:0];
    p_inc    = p_ext + CW'(1);
    slot_d   = (p_inc >= n_eff) ? '0 : p_inc[SLOT_W-1:0];
  end

  // start at the later of ready time and server free time, then saturating add
  always_comb begin
    busy_until = vld_q[p] ? ring_q[p] : '0;
    start      = (busy_until > in_time_i) ? busy_until : in_time_i;
    sum        = {1'b0, start} + (TIME_BITS + 1)'(cfg_i.service);
    done       = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // completion time ring
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring_q[p] <= done;
    end
  end

  // slot pointer and entry valid bits, cleared after the last item of a batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      slot_q <= '0;
    end else if (in_fire) begin
      if (in_last_i) begin
        vld_q  <= '0;
        slot_q <= '0;
      end else begin
        vld_q[p] <= 1'b1;
        slot_q   <= slot_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_arrival_q <= in_arrival_i;
      out_time_q    <= done;
      out_last_q    <= in_last_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_arrival_o = out_arrival_q;
  assign out_time_o    = out_time_q;
  assign out_last_o    = out_last_q;

  `TSQ_ASSERT(a_done_after_ready, in_fire |-> (done >= in_time_i),
              "stage finish earlier than ready time")
  `TSQ_ASSERT(a_last_clears, (in_fire && in_last_i) |=> (slot_q == '0 && vld_q == '0),
              "stage state not cleared after batch end")

endmodule

@@ design/tsq_stats.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsq_stats
// time in system, running maximum per batch and the result register
// ---------------------------------------------------------------------------
`include "three_stage_multiserver_queue_timing_top_macros.svh"

module tsq_stats #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [TIME_BITS-1:0]          in_arrival_i,
  input  logic [TIME_BITS-1:0]          in_exit_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tsq_pkg::FIELD_W-1:0]   out_exit_o,
  output logic [tsq_pkg::FIELD_W-1:0]   out_spent_o,
  output logic [tsq_pkg::FIELD_W-1:0]   out_max_o,
  output logic                          out_last_o
);

  logic                 a_valid_q, a_last_q;
  logic [TIME_BITS-1:0] a_exit_q, a_spent_q;
  logic                 o_valid_q, o_last_q;
  logic [TIME_BITS-1:0] o_exit_q, o_spent_q, o_max_q;
  logic [TIME_BITS-1:0] max_q, max_new;
  logic                 b_ready, a_fire, b_fire;
  logic [63:0]          exit_w, spent_w, max_w;

  assign b_ready    = !o_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || b_ready;
  assign a_fire     = in_valid_i && in_ready_o;
  assign b_fire     = a_valid_q && b_ready;

  // subtract stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      a_exit_q  <= in_exit_i;
      a_spent_q <= in_exit_i - in_arrival_i;
      a_last_q  <= in_last_i;
    end
  end

  // running maximum, back to zero after the last item of a batch
  assign max_new = (a_spent_q > max_q) ? a_spent_q : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (b_fire) begin
        max_q <= a_last_q ? '0 : max_new;
      end
      if (b_ready) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      o_exit_q  <= a_exit_q;
      o_spent_q <= a_spent_q;
      o_max_q   <= max_new;
      o_last_q  <= a_last_q;
    end
  end

  always_comb begin
    exit_w  = 64'(o_exit_q);
    spent_w = 64'(o_spent_q);
    max_w   = 64'(o_max_q);
  end

  assign out_valid_o = o_valid_q;
  assign out_exit_o  = exit_w[tsq_pkg::FIELD_W-1:0];
  assign out_spent_o = spent_w[tsq_pkg::FIELD_W-1:0];
  assign out_max_o   = max_w[tsq_pkg::FIELD_W-1:0];
  assign out_last_o  = o_last_q;

  `TSQ_ASSERT(a_max_covers_item, o_valid_q |-> (o_max_q >= o_spent_q),
              "running maximum below item time in system")

endmodule

@@ design/three_stage_multiserver_queue_timing_top.sv @@
`timescale 1ns / 1ps
// path: an accepted item passes the queue, the three service stages, and the subtract
// and maximum registers, and stalls under back-pressure; throughput: one item per
// cycle when not stalled; each stage updates one ring slot per cycle
// reset: asynchronous, clears queue, rings, slots and running maximum, and sets all
// registers to one; the last item of a batch clears rings, slots and the maximum
// ---------------------------------------------------------------------------
// three_stage_multiserver_queue_timing_top
// tandem multi-server fifo queue timing: front intake queue, three service stages
// ---------------------------------------------------------------------------
module three_stage_multiserver_queue_timing_top #(
  parameter int unsigned MAX_SERVERS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,   // [47:0] arrival_time
  input  logic                          s_axis_tlast,   // last_in_batch
  // result item stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [143:0]                  m_axis_tdata,   // [47:0] exit_time,
                                                        // [95:48] time_in_system,
                                                        // [143:96] max_time_in_system
  output logic                          m_axis_tlast,   // batch_done
  // register write port
  input  logic                          cfg_we_i,
  input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsq_pkg::SVC_W-1:0]     cfg_data_i
);

  tsq_pkg::stage_cfg_t cfg_one, cfg_two, cfg_three;

  logic                 q_valid, q_ready, q_last;
  logic [TIME_BITS-1:0] q_arrival;

  logic                 s1_valid, s1_ready, s1_last;
  logic [TIME_BITS-1:0] s1_arrival, s1_time;
  logic                 s2_valid, s2_ready, s2_last;
  logic [TIME_BITS-1:0] s2_arrival, s2_time;
  logic                 s3_valid, s3_ready, s3_last;
  logic [TIME_BITS-1:0] s3_arrival, s3_time;

  logic [tsq_pkg::FIELD_W-1:0] res_exit, res_spent, res_max;

  // register file
  tsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_one_o   (cfg_one),
    .cfg_two_o   (cfg_two),
    .cfg_three_o (cfg_three)
  );

  // intake and item queue
  tsq_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_arrival_i (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_arrival_o (q_arrival),
    .q_last_o    (q_last)
  );

  // service stages in tandem
  tsq_stage #(.MAX_SERVERS(MAX_SERVERS), .TIME_BITS(TIME_BITS)) u_stage_one (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_one),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_arrival_i  (q_arrival),
    .in_time_i     (q_arrival),
    .in_last_i     (q_last),
    .out_valid_o   (s1_valid),
    .out_ready_i   (s1_ready),
    .out_arrival_o (s1_arrival),
    .out_time_o    (s1_time),
    .out_last_o    (s1_last)
  );

  tsq_stage #(.MAX_SERVERS(MAX_SERVERS), .TIME_BITS(TIME_BITS)) u_stage_two (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_two),
    .in_valid_i    (s1_valid),
    .in_ready_o    (s1_ready),
    .in_arrival_i  (s1_arrival),
    .in_time_i     (s1_time),
    .in_last_i     (s1_last),
    .out_valid_o   (s2_valid),
    .out_ready_i   (s2_ready),
    .out_arrival_o (s2_arrival),
    .out_time_o    (s2_time),
    .out_last_o    (s2_last)
  );

  tsq_stage #(.MAX_SERVERS(MAX_SERVERS), .TIME_BITS(TIME_BITS)) u_stage_three (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_three),
    .in_valid_i    (s2_valid),
    .in_ready_o    (s2_ready),
    .in_arrival_i  (s2_arrival),
    .in_time_i     (s2_time),
    .in_last_i     (s2_last),
    .out_valid_o   (s3_valid),
    .out_ready_i   (s3_ready),
    .out_arrival_o (s3_arrival),
    .out_time_o    (s3_time),
    .out_last_o    (s3_last)
  );

  // time in system and batch maximum
  tsq_stats #(.TIME_BITS(TIME_BITS)) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s3_valid),
    .in_ready_o   (s3_ready),
    .in_arrival_i (s3_arrival),
    .in_exit_i    (s3_time),
    .in_last_i    (s3_last),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_exit_o   (res_exit),
    .out_spent_o  (res_spent),
    .out_max_o    (res_max),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {res_max, res_spent, res_exit};

endmodule

@@ test/tb_three_stage_multiserver_queue_timing_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_three_stage_multiserver_queue_timing_top
// self-checking bench for the tandem queue timing block: customers are
// streamed in batches, an in-bench timing predictor works out the departure of
// each one, and every result item is compared against it in order
// ---------------------------------------------------------------------------
module tb_three_stage_multiserver_queue_timing_top;

  localparam int unsigned MAX_SERVERS = 16;
  localparam int unsigned RUN_LIMIT   = 600000;
  localparam int unsigned RAND_PHASES = 16;
  localparam int unsigned PHASE_ITEMS = 78;

  typedef logic [tsq_pkg::FIELD_W-1:0] tick_t;
  typedef logic [tsq_pkg::SVC_W-1:0]   reg_word_t;

  typedef struct packed {
    tick_t arrival;
    logic  last;
  } customer_t;

  typedef struct packed {
    tick_t exit_t;
    tick_t spent;
    tick_t worst;
    logic  done;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [47:0]   s_axis_tdata  = '0;   // [47:0] arrival_time
  logic          s_axis_tlast  = 1'b0; // last_in_batch
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [143:0]  m_axis_tdata;         // [47:0] exit_time, [95:48] time_in_system,
                                       // [143:96] max_time_in_system
  logic          m_axis_tlast;         // batch_done
  logic                          cfg_we_i   = 1'b0;
  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [tsq_pkg::SVC_W-1:0]     cfg_data_i = '0;

  // predictor state: one completion time per server and stage
  tsq_pkg::stage_cfg_t stage_cfg [3];
  tick_t               ring_done [3][MAX_SERVERS];
  int unsigned         ring_slot [3];
  tick_t               worst_spent;

  customer_t   arrivals_pending[$];
  outcome_t    departures_due[$];

  int unsigned send_wait    = 0;
  int unsigned recv_wait    = 0;
  bit          send_idle_on = 1'b0;
  bit          recv_idle_on = 1'b0;
  int unsigned fault_cnt    = 0;
  int unsigned cycle_cnt    = 0;
  tick_t       batch_clock;

  three_stage_multiserver_queue_timing_top #(
    .MAX_SERVERS(MAX_SERVERS),
    .TIME_BITS  (48)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // idle length: mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void clear_rings();
    for (int s = 0; s < 3; s++) begin
      ring_slot[s] = 0;
      for (int k = 0; k < MAX_SERVERS; k++) ring_done[s][k] = '0;
    end
    worst_spent = '0;
  endfunction

  // one stage: start at the later of ready time and the oldest server
  function automatic tick_t serve_stage(int unsigned s, tick_t ready);
    int unsigned                 n;
    int unsigned                 p;
    tick_t                       start;
    logic [tsq_pkg::FIELD_W:0]   sum;
    n = stage_cfg[s].servers;
    if (n < 1) n = 1;
    if (n > MAX_SERVERS) n = MAX_SERVERS;
    p = ring_slot[s];
    if (p >= n) p = 0;
    start = (ring_done[s][p] > ready) ? ring_done[s][p] : ready;
    sum = {1'b0, start} + stage_cfg[s].service;
    ring_done[s][p] = sum[tsq_pkg::FIELD_W] ? '1 : sum[tsq_pkg::FIELD_W-1:0];
    ring_slot[s] = (p + 1 >= n) ? 0 : p + 1;
    return ring_done[s][p];
  endfunction

  function automatic void predict_departure(tick_t arrival, logic last);
    tick_t    t;
    outcome_t o;
    t = serve_stage(0, arrival);
    t = serve_stage(1, t);
    t = serve_stage(2, t);
    o.exit_t = t;
    o.spent  = t - arrival;
    if (o.spent > worst_spent) worst_spent = o.spent;
    o.worst = worst_spent;
    o.done  = last;
    departures_due.push_back(o);
    // end of batch returns all timing state to reset
    if (last) clear_rings();
  endfunction

  // arrival driver
  always @(posedge clk_i) begin : arrival_driver
    logic      hold_valid;
    customer_t cust;
    hold_valid = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_departure(s_axis_tdata, s_axis_tlast);
      hold_valid = 1'b0;
    end
    if (!hold_valid) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (arrivals_pending.size() > 0) begin
        cust = arrivals_pending.pop_front();
        s_axis_tdata <= cust.arrival;
        s_axis_tlast <= cust.last;
        hold_valid = 1'b1;
        send_wait = send_idle_on ? pick_gap() : 0;
      end
    end
    s_axis_tvalid <= hold_valid;
  end

  // departure monitor and result back-pressure
  always @(posedge clk_i) begin : departure_monitor
    outcome_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (departures_due.size() == 0) begin
        $error("result item with nothing expected");
        fault_cnt++;
      end else begin
        want = departures_due.pop_front();
        if (m_axis_tdata[47:0] !== want.exit_t) begin
          $error("exit_time: expected %0d, got %0d", want.exit_t, m_axis_tdata[47:0]);
          fault_cnt++;
        end
        if (m_axis_tdata[95:48] !== want.spent) begin
          $error("time_in_system: expected %0d, got %0d", want.spent,
                 m_axis_tdata[95:48]);
          fault_cnt++;
        end
        if (m_axis_tdata[143:96] !== want.worst) begin
          $error("max_time_in_system: expected %0d, got %0d", want.worst,
                 m_axis_tdata[143:96]);
          fault_cnt++;
        end
        if (m_axis_tlast !== want.done) begin
          $error("batch_done: expected %0d, got %0d", want.done, m_axis_tlast);
          fault_cnt++;
        end
      end
    end
    if (recv_wait > 0) begin
      recv_wait--;
    end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
      recv_wait = pick_gap();
    end
    m_axis_tready <= (recv_wait == 0);
  end

  // run limit
  initial begin : watchdog
    wait (cycle_cnt >= RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // block until every queued item went in and every result came out
  task automatic settle();
    while (!(arrivals_pending.size() == 0 && !s_axis_tvalid && departures_due.size() == 0))
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(tsq_pkg::cfg_idx_e idx, reg_word_t val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      tsq_pkg::CFG_SRV_ONE:   stage_cfg[0].servers = val[tsq_pkg::SRV_W-1:0];
      tsq_pkg::CFG_SRV_TWO:   stage_cfg[1].servers = val[tsq_pkg::SRV_W-1:0];
      tsq_pkg::CFG_SRV_THREE: stage_cfg[2].servers = val[tsq_pkg::SRV_W-1:0];
      tsq_pkg::CFG_SVC_ONE:   stage_cfg[0].service = val;
      tsq_pkg::CFG_SVC_TWO:   stage_cfg[1].service = val;
      tsq_pkg::CFG_SVC_THREE: stage_cfg[2].service = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(reg_word_t n1, reg_word_t n2, reg_word_t n3,
                           reg_word_t d1, reg_word_t d2, reg_word_t d3);
    set_reg(tsq_pkg::CFG_SRV_ONE, n1);
    set_reg(tsq_pkg::CFG_SRV_TWO, n2);
    set_reg(tsq_pkg::CFG_SRV_THREE, n3);
    set_reg(tsq_pkg::CFG_SVC_ONE, d1);
    set_reg(tsq_pkg::CFG_SVC_TWO, d2);
    set_reg(tsq_pkg::CFG_SVC_THREE, d3);
    @(negedge clk_i);
  endtask

  function automatic void push_customer(tick_t arrival, logic last);
    customer_t c;
    c.arrival = arrival;
    c.last    = last;
    arrivals_pending.push_back(c);
  endfunction

  // server count write: zero, above the limit or in range, junk in upper bits
  function automatic reg_word_t rand_servers();
    reg_word_t   val;
    int unsigned r;
    val = reg_word_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) val[tsq_pkg::SRV_W-1:0] = '0;
    else if (r < 20) val[tsq_pkg::SRV_W-1:0] = tsq_pkg::SRV_W'($urandom_range(17, 31));
    else val[tsq_pkg::SRV_W-1:0] = tsq_pkg::SRV_W'($urandom_range(1, 16));
    return val;
  endfunction

  function automatic reg_word_t rand_service();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 18) return reg_word_t'($urandom_range(1000000000, 1073741823));
    if (r < 22) return reg_word_t'(1000000000);
    return reg_word_t'($urandom_range(1, 24));
  endfunction

  // one batch of customers, mostly nondecreasing with the odd step back
  function automatic void queue_batch(int unsigned len, bit closed);
    int unsigned               r;
    logic [tsq_pkg::FIELD_W:0] sum;
    r = $urandom_range(0, 99);
    if (r < 60) batch_clock = tick_t'($urandom_range(0, 1000));
    else if (r < 85) batch_clock = tick_t'({$urandom, $urandom});
    else batch_clock = '1 - tick_t'($urandom_range(0, 2000));
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        batch_clock = (batch_clock > 50) ? batch_clock - $urandom_range(1, 50) : '0;
      end else begin
        if (r < 62) sum = {1'b0, batch_clock} + $urandom_range(0, 8);
        else if (r < 92) sum = {1'b0, batch_clock} + $urandom_range(0, 64);
        else sum = {1'b0, batch_clock} + $urandom;
        batch_clock = sum[tsq_pkg::FIELD_W] ? '1 : sum[tsq_pkg::FIELD_W-1:0];
      end
      push_customer(batch_clock, closed && (i == len - 1));
    end
  endfunction

  initial begin : stimulus
    int unsigned queued;
    int unsigned len;
    for (int s = 0; s < 3; s++) begin
      stage_cfg[s].servers = 1;
      stage_cfg[s].service = 1;
    end
    clear_rings();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: queueing behind one server, a step back, top arrival time
    push_customer(48'd0, 1'b0);
    push_customer(48'd0, 1'b0);
    push_customer(48'd3, 1'b0);
    push_customer(48'd1, 1'b1);
    push_customer('1, 1'b1);
    settle();

    // zero and oversized server counts, zero and full-scale service times
    configure(30'd0, 30'd31, 30'd16, 30'd0, 30'h3FFF_FFFF, 30'd1000000000);
    push_customer('1 - 48'd5, 1'b0);
    push_customer('1 - 48'd5, 1'b0);
    push_customer(48'h5555_5555_5555, 1'b0);
    push_customer(48'hAAAA_AAAA_AAAA, 1'b0);
    push_customer(48'h0000_0000_0001, 1'b1);
    settle();

    // partly fill the rings of a wide configuration, then shrink it mid-batch
    configure(30'd16, 30'd16, 30'd16, 30'd7, 30'd3, 30'd5);
    for (int i = 0; i < 8; i++) push_customer(48'd0, 1'b0);
    settle();
    configure(30'd3, 30'd2, 30'd1, 30'd7, 30'd3, 30'd5);
    for (int i = 1; i <= 5; i++) push_customer(tick_t'(i), i == 5);
    settle();

    // random phases, each under one setting
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)
        configure(30'd16, 30'd16, 30'd16, '1, '1, '1);
      else if (ph == 1)
        configure(30'd1, 30'd1, 30'd1, 30'd1, 30'd1, 30'd1);
      else
        configure(rand_servers(), rand_servers(), rand_servers(),
                  rand_service(), rand_service(), rand_service());
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 40);
        if (queued + len > PHASE_ITEMS) len = PHASE_ITEMS - queued;
        // a phase may end with its batch still open
        queue_batch(len, (queued + len < PHASE_ITEMS) || ($urandom_range(0, 2) != 0));
        queued += len;
      end
      settle();
    end

    if (fault_cnt == 0 && departures_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
